// ===== design/fhpc_pkg.sv =====
// Shared types, constants and CRC-32 functions for the frame header and payload CRC block.
package fhpc_pkg;

    localparam int CRC_W      = 32;
    localparam int BYTE_W     = 8;
    localparam int HDR_BYTES  = 23;
    localparam int HDR_BITS   = HDR_BYTES * BYTE_W;
    localparam int TDATA_W    = HDR_BITS + BYTE_W;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;
    localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFFFFFF;

    // Kind of an input beat, carried on tuser.
    typedef enum logic
    {
        ACT_START   = 1'b0,
        ACT_PAYLOAD = 1'b1
    } action_t;

    // Header in wire order: the first member sits in the top bits, so the
    // most significant byte of the packed vector is the first byte hashed.
    typedef struct packed
    {
        logic [7:0]  version;
        logic [31:0] frame_number;
        logic [63:0] timestamp_bits;
        logic [31:0] rate_hz;
        logic [7:0]  channel_count;
        logic [7:0]  sample_bits;
        logic [31:0] declared_length;
    } hdr_t;

    typedef logic [HDR_BITS-1:0][CRC_W-1:0] hdr_mat_t;

    // One byte through the reflected CRC-32 register, one bit per step.
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++)
        begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

    // CRC of an all-zero header starting from all ones: the constant part of
    // the header's affine map.
    function automatic logic [CRC_W-1:0] hdr_base();
        logic [CRC_W-1:0] c;
        c = CRC_ONES;
        for (int j = 0; j < HDR_BYTES; j++)
        begin
            c = crc_byte(c, '0);
        end
        return c;
    endfunction

    // Contribution of each single header bit, starting from a zero register.
    // Evaluated only at elaboration.
    function automatic hdr_mat_t hdr_matrix();
        hdr_mat_t         m;
        logic [HDR_BITS-1:0] v;
        logic [CRC_W-1:0] c;
        for (int i = 0; i < HDR_BITS; i++)
        begin
            v    = '0;
            v[i] = 1'b1;
            c    = '0;
            for (int j = 0; j < HDR_BYTES; j++)
            begin
                c = crc_byte(c, v[HDR_BITS-1-BYTE_W*j -: BYTE_W]);
            end
            m[i] = c;
        end
        return m;
    endfunction

    localparam logic [CRC_W-1:0] HDR_BASE = hdr_base();
    localparam hdr_mat_t         HDR_MAT  = hdr_matrix();

    // Header CRC as a flat XOR network: base XOR the columns of the set bits.
    function automatic logic [CRC_W-1:0] hdr_crc(input hdr_t h);
        logic [HDR_BITS-1:0] v;
        logic [CRC_W-1:0]    c;
        v = h;
        c = HDR_BASE;
        for (int i = 0; i < HDR_BITS; i++)
        begin
            c = c ^ (HDR_MAT[i] & {CRC_W{v[i]}});
        end
        return c;
    endfunction

endpackage

// ===== design/fhpc_crc_next.sv =====
// Next value of the running CRC for one staged beat: header restart or one payload byte.
module fhpc_crc_next
    import fhpc_pkg::*;
(
    input  action_t             action,
    input  hdr_t                hdr,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic [CRC_W-1:0]    crc_in,
    output logic [CRC_W-1:0]    crc_out
);

    always_comb
    begin
        unique case (action)
            ACT_START:   crc_out = hdr_crc(hdr);
            ACT_PAYLOAD: crc_out = crc_byte(crc_in, data_byte);
            default:     crc_out = crc_in;
        endcase
    end

endmodule

// ===== design/frame_header_payload_crc32.sv =====
// Top level of the frame header and payload CRC-32 block with its stream ports.
// A tlast beat waits in the input stage until it fires; its checksum is then registered
// and presented on m_tvalid. The header is one XOR network. Throughput: one input beat
// per cycle, set by the single input stage feeding the running CRC register and the
// output register, unless a staged tlast beat meets a full output and a stalled sink.
// Reset: rst_n clears all valid flags and loads the running CRC with all ones.
module frame_header_payload_crc32
    import fhpc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                s_tvalid,
    output logic                s_tready,
    // Fields from bit 0 up: version[7:0], frame_number[39:8],
    // timestamp_bits[103:40], rate_hz[135:104], channel_count[143:136],
    // sample_bits[151:144], declared_length[183:152], data_byte[191:184].
    input  logic [TDATA_W-1:0]  s_tdata,
    // Fields from bit 0 up: action (0 = start with header, 1 = payload byte).
    input  logic                s_tuser,
    input  logic                s_tlast,

    output logic                m_tvalid,
    input  logic                m_tready,
    // Fields from bit 0 up: checksum[31:0].
    output logic [CRC_W-1:0]    m_tdata
);

    // Input stage: one beat waiting to be folded into the running CRC.
    logic                s1_valid_reg;
    action_t             s1_action_reg;
    hdr_t                s1_hdr_reg;
    logic [BYTE_W-1:0]   s1_byte_reg;
    logic                s1_last_reg;

    // Running CRC, all ones whenever no frame is open.
    logic [CRC_W-1:0]    crc_reg;
    logic [CRC_W-1:0]    crc_next;

    // Output register holding a finished checksum beat.
    logic                out_valid_reg;
    logic [CRC_W-1:0]    out_data_reg;

    logic                s1_fire;
    logic                s_fire;
    hdr_t                in_hdr;

    // The staged beat moves on unless it would produce a checksum while the
    // output register is still full and the sink is stalling.
    assign s1_fire  = s1_valid_reg && (!s1_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_fire;
    assign s_fire   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Unpack tdata into header order.
    always_comb
    begin
        in_hdr.version         = s_tdata[7:0];
        in_hdr.frame_number    = s_tdata[39:8];
        in_hdr.timestamp_bits  = s_tdata[103:40];
        in_hdr.rate_hz         = s_tdata[135:104];
        in_hdr.channel_count   = s_tdata[143:136];
        in_hdr.sample_bits     = s_tdata[151:144];
        in_hdr.declared_length = s_tdata[183:152];
    end

    fhpc_crc_next u_crc_next
    (
        .action    (s1_action_reg),
        .hdr       (s1_hdr_reg),
        .data_byte (s1_byte_reg),
        .crc_in    (crc_reg),
        .crc_out   (crc_next)
    );

    // Control state and the running CRC.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            crc_reg       <= CRC_ONES;
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end

            if (s1_fire)
            begin
                // A frame end re-arms the register for the next frame.
                crc_reg <= s1_last_reg ? CRC_ONES : crc_next;
            end

            if (s1_fire && s1_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_action_reg <= action_t'(s_tuser);
            s1_hdr_reg    <= in_hdr;
            s1_byte_reg   <= s_tdata[TDATA_W-1 -: BYTE_W];
            s1_last_reg   <= s_tlast;
        end

        if (s1_fire && s1_last_reg)
        begin
            out_data_reg <= ~crc_next;
        end
    end

endmodule

// ===== tb/tb_frame_header_payload_crc32.sv =====
// Self-checking testbench for the frame header and payload CRC-32 block.
module tb_frame_header_payload_crc32;
    timeunit 1ns;
    timeprecision 1ps;

    import fhpc_pkg::*;

    // Run length and timing bounds. A checksum follows its tlast beat through the
    // input stage and output register; the drain cycles run once none is pending.
    localparam int N_ITEMS      = 1250;
    localparam int QUIET_AFTER  = 1100;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    // One input beat as the stimulus sees it, with an optional checksum that
    // is known without running the predictor.
    typedef struct
    {
        action_t     kind;
        hdr_t        hdr;
        logic [7:0]  data_byte;
        logic        last;
        logic        has_known;
        logic [31:0] known_sum;
    } beat_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata;
    logic                s_tuser;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [CRC_W-1:0]    m_tdata;

    // Predictor state: the running CRC register as the block should hold it.
    logic [CRC_W-1:0]    running_sum;
    // Checksums that the block still owes, oldest first.
    logic [CRC_W-1:0]    checksum_q[$];
    logic [CRC_W-1:0]    wanted_sum;
    beat_t               stim_rows[$];

    int  errors       = 0;
    int  items_sent   = 0;
    int  sums_seen    = 0;
    int  cycle_count  = 0;
    // Sender gaps are allowed while gap_ok is set; quiet turns off all idling.
    bit  gap_ok       = 1'b1;
    bit  quiet        = 1'b0;
    // Set by the sender to make the receiver hold off for a long stretch.
    bit  hold_req     = 1'b0;

    frame_header_payload_crc32 uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        errors++;
    endtask

    // One byte through the reflected CRC register, least significant bit first.
    // Each step shifts right and folds in the polynomial when the bit that
    // falls out differs from the data bit.
    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] c,
                                                  input logic [7:0] b);
        logic [CRC_W-1:0] r;
        r = c;
        for (int i = 0; i < 8; i++)
        begin
            if (r[0] ^ b[i])
                r = (r >> 1) ^ CRC_POLY;
            else
                r = r >> 1;
        end
        return r;
    endfunction

    // CRC register after a fresh start and the 23 header bytes. The packed
    // header keeps the version in its top byte, so walking bytes from the top
    // down gives the big-endian wire order.
    function automatic logic [CRC_W-1:0] header_crc(input hdr_t h);
        logic [HDR_BITS-1:0] v;
        logic [CRC_W-1:0]    c;
        v = h;
        c = CRC_ONES;
        for (int j = 0; j < HDR_BYTES; j++)
        begin
            c = crc_feed(c, v[HDR_BITS-1-8*j -: 8]);
        end
        return c;
    endfunction

    // tdata carries the version in the lowest byte and the payload byte in
    // the highest one, the reverse of the header struct's order.
    function automatic logic [TDATA_W-1:0] pack_tdata(input hdr_t h, input logic [7:0] d);
        return {d, h.declared_length, h.sample_bits, h.channel_count,
                h.rate_hz, h.timestamp_bits, h.frame_number, h.version};
    endfunction

    function automatic beat_t mk_beat(input action_t kind, input hdr_t h,
                                      input logic [7:0] d, input logic last,
                                      input logic has_known = 1'b0,
                                      input logic [31:0] known_sum = '0);
        beat_t b;
        b.kind      = kind;
        b.hdr       = h;
        b.data_byte = d;
        b.last      = last;
        b.has_known = has_known;
        b.known_sum = known_sum;
        return b;
    endfunction

    // Updates the predicted register for one accepted beat and queues the
    // checksum when the beat closes a frame. A start beat drops whatever was
    // running; a payload beat continues from the current register.
    task automatic predict_checksum(input beat_t b);
        logic [CRC_W-1:0] c;
        if (b.kind == ACT_START)
            c = header_crc(b.hdr);
        else
            c = crc_feed(running_sum, b.data_byte);
        if (b.last)
        begin
            checksum_q.push_back(b.has_known ? b.known_sum : ~c);
            running_sum = CRC_ONES;
        end
        else
        begin
            running_sum = c;
        end
    endtask

    // Field values lean toward the extremes now and then so that every bit
    // is seen both set and clear, and all-zero and all-one words show up.
    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic hdr_t rand_hdr();
        hdr_t h;
        h.version         = 8'($urandom_range(0, 255));
        h.frame_number    = pick32();
        h.timestamp_bits  = {pick32(), pick32()};
        h.rate_hz         = pick32();
        h.channel_count   = 8'($urandom_range(0, 255));
        h.sample_bits     = 8'($urandom_range(0, 255));
        h.declared_length = pick32();
        return h;
    endfunction

    // Offers one beat and waits for the handshake. The task is entered and
    // left at a falling edge; tvalid stays high from one beat to the next
    // unless a gap is inserted, so it is written once per step at most.
    task automatic send_beat(input beat_t b);
        if (gap_ok && !quiet && $urandom_range(0, 4) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = pack_tdata(b.hdr, b.data_byte);
        s_tuser  = b.kind;
        s_tlast  = b.last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_checksum(b);
        items_sent++;
        if (items_sent >= QUIET_AFTER)
            quiet = 1'b1;
        @(negedge clk);
    endtask

    // One random frame. Most are well formed: a start beat with the header
    // and a run of payload bytes, the last beat closing the frame. The rest
    // are payload runs with no start, and frames that are abandoned without
    // a tlast so that the next start lands in the middle of a frame.
    task automatic random_frame();
        int kind;
        int len;
        kind = $urandom_range(0, 9);
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
        if (kind < 8)
        begin
            send_beat(mk_beat(ACT_START, rand_hdr(), 8'($urandom_range(0, 255)), len == 0));
            for (int i = 0; i < len; i++)
                send_beat(mk_beat(ACT_PAYLOAD, rand_hdr(), 8'($urandom_range(0, 255)),
                                  i == len - 1));
        end
        else if (kind == 8)
        begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                send_beat(mk_beat(ACT_PAYLOAD, rand_hdr(), 8'($urandom_range(0, 255)),
                                  i == len - 1));
        end
        else
        begin
            send_beat(mk_beat(ACT_START, rand_hdr(), 8'($urandom_range(0, 255)), 1'b0));
            for (int i = 0; i < len; i++)
                send_beat(mk_beat(ACT_PAYLOAD, rand_hdr(), 8'($urandom_range(0, 255)),
                                  1'b0));
        end
    endtask

    // Directed beats. The first frames are payload-only right after reset or
    // after an emitted checksum, so they are plain CRC-32 values that are
    // well known: one zero byte, one 0xFF byte and the ASCII string
    // "123456789". The header frames that follow go through the predictor.
    task automatic build_rows();
        hdr_t z;
        hdr_t o;
        hdr_t mix;
        hdr_t alt;
        z   = '0;
        o   = '1;
        mix = {8'h01, 32'hDEADBEEF, 64'h400921FB54442D18, 32'd48000, 8'd2, 8'd16, 32'd4};
        alt = {8'hA5, 32'h0000_0001, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF,
               8'hFF, 8'h00, 32'h8000_0000};

        stim_rows.push_back(mk_beat(ACT_PAYLOAD, z, 8'h00, 1'b1, 1'b1, 32'hD202EF8D));
        stim_rows.push_back(mk_beat(ACT_PAYLOAD, o, 8'hFF, 1'b1, 1'b1, 32'hFF000000));
        // Header fields on payload beats must be ignored, so some of the
        // string beats carry all-ones headers.
        for (int i = 1; i <= 9; i++)
            stim_rows.push_back(mk_beat(ACT_PAYLOAD, (i % 2) ? o : z, 8'(8'h30 + i), i == 9,
                                        i == 9, 32'hCBF43926));
        // Start beats with tlast set: a frame with an empty payload.
        stim_rows.push_back(mk_beat(ACT_START, z, 8'h00, 1'b1));
        stim_rows.push_back(mk_beat(ACT_START, o, 8'hFF, 1'b1));
        // A normal frame with a short payload.
        stim_rows.push_back(mk_beat(ACT_START, mix, 8'h77, 1'b0));
        stim_rows.push_back(mk_beat(ACT_PAYLOAD, mix, 8'h00, 1'b0));
        stim_rows.push_back(mk_beat(ACT_PAYLOAD, z, 8'hFF, 1'b0));
        stim_rows.push_back(mk_beat(ACT_PAYLOAD, o, 8'hA5, 1'b0));
        stim_rows.push_back(mk_beat(ACT_PAYLOAD, z, 8'h5A, 1'b1));
        // A start in the middle of a frame drops the partial CRC.
        stim_rows.push_back(mk_beat(ACT_START, alt, 8'h00, 1'b0));
        stim_rows.push_back(mk_beat(ACT_PAYLOAD, z, 8'h3C, 1'b0));
        stim_rows.push_back(mk_beat(ACT_START, mix, 8'hFF, 1'b0));
        stim_rows.push_back(mk_beat(ACT_PAYLOAD, alt, 8'hC3, 1'b1));
        // Payload with no start after an emitted checksum restarts from ones.
        stim_rows.push_back(mk_beat(ACT_PAYLOAD, o, 8'h80, 1'b0));
        stim_rows.push_back(mk_beat(ACT_PAYLOAD, z, 8'h01, 1'b1));
    endtask

    // Receiver: random stalls in short bursts, a long hold-off on request,
    // and no stalls at all once the run goes quiet.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            else
            begin
                m_tready = 1'b1;
                @(negedge clk);
            end
        end
    end

    // Checksum beats are compared with the oldest expectation at the edge
    // where they are taken.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (checksum_q.size() == 0)
            begin
                report_error($sformatf("checksum beat %0d arrived with none pending: %h",
                                       sums_seen, m_tdata));
            end
            else
            begin
                wanted_sum = checksum_q.pop_front();
                if (m_tdata !== wanted_sum)
                    report_error($sformatf("checksum beat %0d: got %h, want %h",
                                           sums_seen, m_tdata, wanted_sum));
            end
            sums_seen++;
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int frame_idx;
        int stop_at;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        s_tlast     = 1'b0;
        rst_n       = 1'b0;
        running_sum = CRC_ONES;
        build_rows();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (stim_rows[i])
            send_beat(stim_rows[i]);

        stop_at   = N_ITEMS + stim_rows.size();
        frame_idx = 0;
        while (items_sent < stop_at)
        begin
            frame_idx++;
            if (frame_idx == 15)
            begin
                // The receiver stops for a long stretch while empty frames
                // keep coming back to back, so the output and input stages
                // fill and s_tready must drop.
                gap_ok   = 1'b0;
                hold_req = 1'b1;
                repeat (12)
                    send_beat(mk_beat(ACT_START, rand_hdr(), 8'($urandom_range(0, 255)),
                                      1'b1));
                gap_ok = 1'b1;
            end
            else if (frame_idx == 30)
            begin
                // The sender goes idle until every checksum has come back.
                s_tvalid = 1'b0;
                while (checksum_q.size() != 0) @(negedge clk);
                repeat (4) @(negedge clk);
            end
            random_frame();
        end
        s_tvalid = 1'b0;

        while (checksum_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
